// ===== rtl/dpr_pkg.sv =====
// Shared types, constants and the ramp reciprocal table for the drive PID core.
`default_nettype none

package dpr_pkg;

  // Defaults for the top-level parameters
  localparam int GAIN_FRAC_BITS_DEF = 8;
  localparam int MAX_POWER_DEF      = 100;
  localparam int SENSOR_WIDTH_DEF   = 16;

  // Register field widths
  localparam int GAIN_W   = 10;
  localparam int WIN_W    = 12;
  localparam int TICKS_W  = 4;
  localparam int LIMIT_W  = 7;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 12;

  // State and result widths
  localparam int INTEG_W  = 24;
  localparam int RAMP_W   = 5;
  localparam int TICK_W   = 4;
  localparam int POWER_W  = 8;

  // Ramp: factor is ramp_step / 20, command computed as mag * recip >> 16
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 16;

  localparam logic [RAMP_W-1:0] RAMP_START = RAMP_W'(5);
  localparam logic [RAMP_W-1:0] RAMP_FULL  = RAMP_W'(20);
  localparam logic [TICK_W-1:0] TICK_MAX   = TICK_W'(15);

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  // Register reset values
  localparam logic               TURN_MODE_RST = 1'b0;
  localparam logic [GAIN_W-1:0]  KP_RST        = GAIN_W'(179);
  localparam logic [GAIN_W-1:0]  KI_RST        = GAIN_W'(38);
  localparam logic [GAIN_W-1:0]  KD_RST        = GAIN_W'(320);
  localparam logic [WIN_W-1:0]   WINDOW_RST    = WIN_W'(100);
  localparam logic [TICKS_W-1:0] SU_TICKS_RST  = TICKS_W'(4);
  localparam logic [LIMIT_W-1:0] SU_LIMIT_RST  = LIMIT_W'(50);

  typedef enum logic [CFG_AW-1:0] {
    REG_TURN_MODE     = 3'd0,
    REG_KP_GAIN       = 3'd1,
    REG_KI_GAIN       = 3'd2,
    REG_KD_GAIN       = 3'd3,
    REG_WINDOW        = 3'd4,
    REG_STARTUP_TICKS = 3'd5,
    REG_STARTUP_LIMIT = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic               turn_mode;
    logic [GAIN_W-1:0]  kp_gain;
    logic [GAIN_W-1:0]  ki_gain;
    logic [GAIN_W-1:0]  kd_gain;
    logic [WIN_W-1:0]   integral_window;
    logic [TICKS_W-1:0] startup_ticks;
    logic [LIMIT_W-1:0] startup_limit;
  } cfg_t;

  // Step strobes from the sequencer to the datapath
  typedef struct packed {
    logic load;
    logic mul_p;
    logic mul_i;
    logic mul_d;
    logic sum;
    logic pwr;
    logic emit;
  } dp_cmd_t;

  // ceil(r * 2^16 / 20): exact floor of mag*r/20 for mag below 128
  function automatic logic [RECIP_W-1:0] ramp_recip(input logic [RAMP_W-1:0] r);
    logic [RECIP_W-1:0] k;
    case (r)
      5'd0:    k = 17'd0;
      5'd1:    k = 17'd3277;
      5'd2:    k = 17'd6554;
      5'd3:    k = 17'd9831;
      5'd4:    k = 17'd13108;
      5'd5:    k = 17'd16384;
      5'd6:    k = 17'd19661;
      5'd7:    k = 17'd22938;
      5'd8:    k = 17'd26215;
      5'd9:    k = 17'd29492;
      5'd10:   k = 17'd32768;
      5'd11:   k = 17'd36045;
      5'd12:   k = 17'd39322;
      5'd13:   k = 17'd42599;
      5'd14:   k = 17'd45876;
      5'd15:   k = 17'd49152;
      5'd16:   k = 17'd52429;
      5'd17:   k = 17'd55706;
      5'd18:   k = 17'd58983;
      5'd19:   k = 17'd62260;
      default: k = 17'd65536;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/drive_pid_with_ramp_core.sv =====
// Drive PID core top level: config registers, sequencer and datapath.
//
// One input word is one control tick: start flag, encoder count, gyro
// heading and target. One output word comes back per tick: the clamped
// drive power and the ramp-scaled motor command.
// Both channels use valid/ready; a word moves when both are high.
// An accepted tick runs these steps: load, three products through the one
// shared 10-bit gain multiplier (P, I, D), the P+D sum, the power clamp and
// the ramp scaling into the output register. in_ready is high only while the
// sequencer is idle, so a new tick is taken only after the last one is done.
// The result sits in an output register; the next tick is taken while it
// waits. If the receiver stalls, the following tick waits in its last step
// until the output word has been taken. Reset clears origins, integral,
// previous error and tick count, puts the ramp at 0.25 and loads the default
// gains; no clearing pass is needed. Registers must be written through
// cfg_we/cfg_addr/cfg_wdata only while idle; the block does not enforce it.
`default_nettype none

module drive_pid_with_ramp_core import dpr_pkg::*; #(
  parameter int SENSOR_WIDTH   = SENSOR_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  parameter int MAX_POWER      = MAX_POWER_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_start_req,
  input  wire logic signed [SENSOR_WIDTH-1:0] in_encoder_count,
  input  wire logic signed [SENSOR_WIDTH-1:0] in_gyro_heading,
  input  wire logic signed [SENSOR_WIDTH-1:0] in_target_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [POWER_W-1:0]           out_drive_power,
  output logic signed [POWER_W-1:0]           out_motor_command,
  input  wire logic                           cfg_we,
  input  wire logic [CFG_AW-1:0]              cfg_addr,
  input  wire logic [CFG_DW-1:0]              cfg_wdata
);

  cfg_t    cfg;
  dp_cmd_t cmd;

  dpr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  dpr_datapath #(
    .SENSOR_WIDTH   (SENSOR_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .MAX_POWER      (MAX_POWER)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg              (cfg),
    .in_start_req     (in_start_req),
    .in_encoder_count (in_encoder_count),
    .in_gyro_heading  (in_gyro_heading),
    .in_target_value  (in_target_value),
    .drive_power      (out_drive_power),
    .motor_command    (out_motor_command)
  );

  // busy straight after taking a tick
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again while a tick is in progress");

  a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_drive_power <= MAX_POWER && out_drive_power >= -MAX_POWER))
    else $error("drive power outside clamp range");

  // ramp factor is at most 1 and keeps the sign
  a_cmd_within_power: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_drive_power[POWER_W-1]
      ? (out_motor_command <= 0 && out_motor_command >= out_drive_power)
      : (out_motor_command >= 0 && out_motor_command <= out_drive_power)))
    else $error("motor command exceeds drive power");

endmodule

`default_nettype wire

// ===== rtl/dpr_cfg_regs.sv =====
// Configuration register file: turn mode, gains, integral window and startup limits.
`default_nettype none

module dpr_cfg_regs import dpr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_DW-1:0] cfg_wdata,
  output cfg_t                   cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_TURN_MODE:     cfg_nxt.turn_mode       = cfg_wdata[0];
        REG_KP_GAIN:       cfg_nxt.kp_gain         = cfg_wdata[GAIN_W-1:0];
        REG_KI_GAIN:       cfg_nxt.ki_gain         = cfg_wdata[GAIN_W-1:0];
        REG_KD_GAIN:       cfg_nxt.kd_gain         = cfg_wdata[GAIN_W-1:0];
        REG_WINDOW:        cfg_nxt.integral_window = cfg_wdata[WIN_W-1:0];
        REG_STARTUP_TICKS: cfg_nxt.startup_ticks   = cfg_wdata[TICKS_W-1:0];
        REG_STARTUP_LIMIT: cfg_nxt.startup_limit   = cfg_wdata[LIMIT_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.turn_mode       <= TURN_MODE_RST;
      cfg_r.kp_gain         <= KP_RST;
      cfg_r.ki_gain         <= KI_RST;
      cfg_r.kd_gain         <= KD_RST;
      cfg_r.integral_window <= WINDOW_RST;
      cfg_r.startup_ticks   <= SU_TICKS_RST;
      cfg_r.startup_limit   <= SU_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/dpr_ctrl.sv =====
// Sequencer: input/output handshakes and the step strobes for the datapath.
`default_nettype none

module dpr_ctrl import dpr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output dp_cmd_t   cmd
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL_P = 7'b0000010,
    ST_MUL_I = 7'b0000100,
    ST_MUL_D = 7'b0001000,
    ST_SUM   = 7'b0010000,
    ST_PWR   = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  // output word may be replaced when empty or being taken this cycle
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        cmd.mul_p = 1'b1;
        state_nxt = ST_MUL_I;
      end
      ST_MUL_I: begin
        cmd.mul_i = 1'b1;
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D: begin
        cmd.mul_d = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_PWR;
      end
      ST_PWR: begin
        cmd.pwr   = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/dpr_datapath.sv =====
// PID datapath: error, shared gain multiplier, windowed integral, clamps, ramp.
`default_nettype none

module dpr_datapath import dpr_pkg::*; #(
  parameter int SENSOR_WIDTH   = SENSOR_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  parameter int MAX_POWER      = MAX_POWER_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire dp_cmd_t                        cmd,
  input  wire cfg_t                           cfg,
  input  wire logic                           in_start_req,
  input  wire logic signed [SENSOR_WIDTH-1:0] in_encoder_count,
  input  wire logic signed [SENSOR_WIDTH-1:0] in_gyro_heading,
  input  wire logic signed [SENSOR_WIDTH-1:0] in_target_value,
  output logic signed [POWER_W-1:0]           drive_power,
  output logic signed [POWER_W-1:0]           motor_command
);

  localparam int EW   = SENSOR_WIDTH + 2;                    // error
  localparam int DW   = EW + 1;                              // error difference
  localparam int PW   = DW + GAIN_W;                         // gain product
  localparam int SUMW = PW + 1;                              // P + D
  localparam int IAW  = ((PW > INTEG_W) ? PW : INTEG_W) + 1; // integral add
  localparam int XW   = ((SUMW > INTEG_W) ? SUMW : INTEG_W) + 1;
  localparam int CPW  = POWER_W + RECIP_W;

  localparam logic signed [SUMW-1:0] PD_BIAS = SUMW'((1 << GAIN_FRAC_BITS) - 1);
  localparam logic signed [XW-1:0]   X_BIAS  = XW'((1 << GAIN_FRAC_BITS) - 1);
  localparam logic signed [XW-1:0]   MAXP    = XW'(MAX_POWER);
  localparam logic signed [IAW-1:0]  IMAX    = IAW'(INTEG_MAX);
  localparam logic signed [IAW-1:0]  IMIN    = IAW'(INTEG_MIN);

  // state kept between ticks
  logic signed [SENSOR_WIDTH-1:0] enc_org_r, gyr_org_r;
  logic signed [INTEG_W-1:0]      integ_r, integ_nxt;
  logic signed [EW-1:0]           prev_r;
  logic [TICK_W-1:0]              tick_r;
  logic [RAMP_W-1:0]              ramp_r;

  // per-tick working registers
  logic signed [EW-1:0]      err_r;
  logic                      win_r;
  logic signed [PW-1:0]      prod_r;
  logic signed [PW-1:0]      pd_r;
  logic signed [SUMW-1:0]    pdt_r;
  logic signed [POWER_W-1:0] pwr_r;
  logic signed [POWER_W-1:0] power_out_r, cmd_out_r;

  // ---- error at accept ----
  logic signed [EW-1:0] enc_rel, gyr_rel, err_enc, err_gyr, err_in;

  always_comb begin
    if (in_start_req) begin
      enc_rel = '0;
      gyr_rel = '0;
    end else begin
      enc_rel = EW'(in_encoder_count) - EW'(enc_org_r);
      gyr_rel = EW'(in_gyro_heading) - EW'(gyr_org_r);
    end
    err_enc = EW'(in_target_value) - enc_rel;
    err_gyr = gyr_rel - EW'(in_target_value);
    err_in  = cfg.turn_mode ? err_gyr : err_enc;
  end

  // ---- window test ----
  logic [EW-1:0] err_mag;
  logic          win_nxt;

  always_comb begin
    err_mag = err_r[EW-1] ? EW'(-err_r) : EW'(err_r);
    win_nxt = err_mag < {{(EW-WIN_W){1'b0}}, cfg.integral_window};
  end

  // ---- shared multiplier ----
  logic signed [DW-1:0] mul_a;
  logic [GAIN_W-1:0]    mul_b;
  logic signed [PW-1:0] prod_nxt;

  always_comb begin
    if (cmd.mul_d) begin
      mul_a = DW'(err_r) - DW'(prev_r);
      mul_b = cfg.kd_gain;
    end else if (cmd.mul_i) begin
      mul_a = DW'(err_r);
      mul_b = cfg.ki_gain;
    end else begin
      mul_a = DW'(err_r);
      mul_b = cfg.kp_gain;
    end
    prod_nxt = PW'(mul_a) * PW'($signed({1'b0, mul_b}));
  end

  // ---- integral, saturating, cleared outside the window; prod_r holds the ki product in the D step ----
  logic signed [IAW-1:0] iacc;

  always_comb begin
    iacc = IAW'(integ_r) + IAW'(prod_r);
    if (!win_r) begin
      integ_nxt = '0;
    end else if (iacc > IMAX) begin
      integ_nxt = INTEG_MAX;
    end else if (iacc < IMIN) begin
      integ_nxt = INTEG_MIN;
    end else begin
      integ_nxt = INTEG_W'(iacc);
    end
  end

  // ---- P + D, truncated toward zero ----
  logic signed [SUMW-1:0] pd_full, pd_trunc;

  always_comb begin
    pd_full  = SUMW'(pd_r) + SUMW'(prod_r);
    pd_trunc = (pd_full + (pd_full[SUMW-1] ? PD_BIAS : $signed(SUMW'(0)))) >>> GAIN_FRAC_BITS;
  end

  // ---- power: add integral, truncate, clamp ----
  logic signed [XW-1:0] x_sum, x_trunc, lim, su_lim, pwr_cl;
  logic                 in_startup;

  always_comb begin
    x_sum      = (XW'(pdt_r) <<< GAIN_FRAC_BITS) + XW'(integ_r);
    x_trunc    = (x_sum + (x_sum[XW-1] ? X_BIAS : $signed(XW'(0)))) >>> GAIN_FRAC_BITS;
    su_lim     = XW'($signed({1'b0, cfg.startup_limit}));
    in_startup = tick_r < cfg.startup_ticks;
    lim        = (in_startup && (su_lim < MAXP)) ? su_lim : MAXP;
    if (x_trunc > lim) begin
      pwr_cl = lim;
    end else if (x_trunc < -lim) begin
      pwr_cl = -lim;
    end else begin
      pwr_cl = x_trunc;
    end
  end

  // ---- ramp scaling, toward zero ----
  logic [POWER_W-1:0]        pwr_mag;
  logic [CPW-1:0]            cprod;
  logic [POWER_W-1:0]        cmd_mag;
  logic signed [POWER_W-1:0] cmd_val;

  always_comb begin
    pwr_mag = pwr_r[POWER_W-1] ? POWER_W'(-pwr_r) : POWER_W'(pwr_r);
    cprod   = CPW'(pwr_mag) * CPW'(ramp_recip(ramp_r));
    cmd_mag = cprod[RECIP_SHIFT +: POWER_W];
    cmd_val = pwr_r[POWER_W-1] ? -$signed(cmd_mag) : $signed(cmd_mag);
  end

  // ---- tick state ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_org_r <= '0;
      gyr_org_r <= '0;
      integ_r   <= '0;
      prev_r    <= '0;
      tick_r    <= '0;
      ramp_r    <= RAMP_START;
    end else begin
      if (cmd.load && in_start_req) begin
        enc_org_r <= in_encoder_count;
        gyr_org_r <= in_gyro_heading;
        integ_r   <= '0;
        prev_r    <= '0;
        tick_r    <= '0;
        ramp_r    <= RAMP_START;
      end
      if (cmd.mul_d) begin
        integ_r <= integ_nxt;
      end
      if (cmd.sum) begin
        prev_r <= err_r;
      end
      if (cmd.emit) begin
        if (tick_r < TICK_MAX) begin
          tick_r <= tick_r + TICK_W'(1);
        end
        if (ramp_r < RAMP_FULL) begin
          ramp_r <= ramp_r + RAMP_W'(1);
        end
      end
    end
  end

  // ---- working registers ----
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err_r <= err_in;
    end
    if (cmd.mul_p) begin
      win_r <= win_nxt;
    end
    if (cmd.mul_p || cmd.mul_i || cmd.mul_d) begin
      prod_r <= prod_nxt;
    end
    if (cmd.mul_i) begin
      pd_r <= prod_r;
    end
    if (cmd.sum) begin
      pdt_r <= pd_trunc;
    end
    if (cmd.pwr) begin
      pwr_r <= POWER_W'(pwr_cl);
    end
    if (cmd.emit) begin
      power_out_r <= pwr_r;
      cmd_out_r   <= cmd_val;
    end
  end

  assign drive_power   = power_out_r;
  assign motor_command = cmd_out_r;

endmodule

`default_nettype wire
